/* hw/rtl/crg_pkg.sv */
// ----------------------------------------------------------------------------
// crg_pkg
// Shared constants and codes for the circle raster generator.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;

  // Result coordinates are always this wide, two's complement.
  localparam int OUT_BITS = 13;

  // Depth of the step queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One step gives at most eight results.
  localparam int IDX_BITS = 3;
  localparam logic [IDX_BITS-1:0] LAST_IDX_LINE = 3'd7;
  localparam logic [IDX_BITS-1:0] LAST_IDX_FILL = 3'd3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    MODE_LINE = 1'b0,
    MODE_FILL = 1'b1
  } mode_t;

endpackage

/* hw/rtl/crg_queue.sv */
// ----------------------------------------------------------------------------
// crg_queue
// Short first-in first-out queue of step words between front and back.
// ----------------------------------------------------------------------------
module crg_queue import crg_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/crg_front.sv */
// ----------------------------------------------------------------------------
// crg_front
// Takes commands while the queue has room, holds the circle state and
// advances the decision variables one step per cycle, queueing step snapshots.
// ----------------------------------------------------------------------------
module crg_front import crg_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int OW          = RADIUS_BITS + 2,
  parameter int EW          = 2 + 2 * COORD_BITS + 2 * OW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0]       circle_radius,
  input  logic                         fill_mode,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [EW-1:0]                q_data
);

  localparam int DW = RADIUS_BITS + 4;
  localparam logic signed [DW-1:0] ONE_D = DW'(1);
  localparam logic signed [DW-1:0] TWO_D = DW'(2);
  localparam logic signed [OW-1:0] ONE_O = OW'(1);

  logic                         active;
  logic                         mode_is_fill;
  logic signed [COORD_BITS-1:0] ctr_x;
  logic signed [COORD_BITS-1:0] ctr_y;
  logic [RADIUS_BITS-1:0]       rad;
  logic signed [OW-1:0]         offset_major;
  logic signed [OW-1:0]         offset_minor;
  logic signed [DW-1:0]         decision;
  logic signed [DW-1:0]         incr_tx;
  logic signed [DW-1:0]         incr_ty;

  logic                 accept;
  logic signed [DW-1:0] rad_new;
  logic signed [OW-1:0] major_start;
  logic signed [DW-1:0] dec_start;

  logic signed [DW-1:0] rad_w;
  logic signed [DW-1:0] maj_w;
  logic signed [DW-1:0] min_w;

  // Outline update, in two dependent halves.
  logic                 ln_up;
  logic signed [DW-1:0] ln_dec1;
  logic signed [OW-1:0] ln_min1;
  logic signed [DW-1:0] ln_ty1;
  logic                 ln_left;
  logic signed [DW-1:0] ln_tx2;
  logic signed [DW-1:0] ln_dec2;
  logic signed [OW-1:0] ln_maj2;

  // Fill update.
  logic signed [DW-1:0] fl_dec;
  logic signed [OW-1:0] fl_maj;
  logic signed [OW-1:0] fl_min;

  logic signed [OW-1:0] major_next;
  logic signed [OW-1:0] minor_next;
  logic signed [DW-1:0] decision_next;
  logic                 active_next;

  assign accept  = push && !q_full;
  assign rad_new = signed'({{(DW - RADIUS_BITS){1'b0}}, circle_radius});

  always_comb begin
    if (fill_mode == MODE_FILL) begin
      major_start = OW'(rad_new);
      dec_start   = rad_new - ONE_D;
    end else begin
      major_start = OW'(rad_new - ONE_D);
      dec_start   = ONE_D - (rad_new <<< 1);
    end
  end

  assign rad_w = signed'({{(DW - RADIUS_BITS){1'b0}}, rad});
  assign maj_w = DW'(offset_major);
  assign min_w = DW'(offset_minor);

  always_comb begin
    ln_up   = decision[DW-1] || (decision == '0);
    ln_dec1 = ln_up ? decision + incr_ty : decision;
    ln_min1 = ln_up ? offset_minor + ONE_O : offset_minor;
    ln_ty1  = ln_up ? incr_ty + TWO_D : incr_ty;
    ln_left = !ln_dec1[DW-1] && (ln_dec1 != '0);
    ln_tx2  = ln_left ? incr_tx + TWO_D : incr_tx;
    ln_dec2 = ln_left ? ln_dec1 + incr_tx + TWO_D - (rad_w <<< 1) : ln_dec1;
    ln_maj2 = ln_left ? offset_major - ONE_O : offset_major;
  end

  always_comb begin
    if (decision >= (min_w <<< 1)) begin
      fl_dec = decision - (min_w <<< 1) - ONE_D;
      fl_maj = offset_major;
      fl_min = offset_minor + ONE_O;
    end else if (decision < ((rad_w - maj_w) <<< 1)) begin
      fl_dec = decision + (maj_w <<< 1) - ONE_D;
      fl_maj = offset_major - ONE_O;
      fl_min = offset_minor;
    end else begin
      fl_dec = decision + ((maj_w - min_w - ONE_D) <<< 1);
      fl_maj = offset_major - ONE_O;
      fl_min = offset_minor + ONE_O;
    end
  end

  always_comb begin
    if (mode_is_fill == MODE_FILL) begin
      major_next    = fl_maj;
      minor_next    = fl_min;
      decision_next = fl_dec;
    end else begin
      major_next    = ln_maj2;
      minor_next    = ln_min1;
      decision_next = ln_dec2;
    end
    active_next = (major_next >= minor_next);
  end

  assign q_push = accept && (operation == OP_STEP) && active;
  assign q_data = {mode_is_fill, !active_next, ctr_x, ctr_y, offset_major, offset_minor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (operation == OP_START) begin
        active <= (major_start >= 0);
      end else if (active) begin
        active <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (operation == OP_START) begin
        ctr_x        <= center_x;
        ctr_y        <= center_y;
        rad          <= circle_radius;
        mode_is_fill <= fill_mode;
        offset_major <= major_start;
        offset_minor <= '0;
        decision     <= dec_start;
        incr_tx      <= ONE_D;
        incr_ty      <= ONE_D;
      end else if (active) begin
        offset_major <= major_next;
        offset_minor <= minor_next;
        decision     <= decision_next;
        if (mode_is_fill == MODE_LINE) begin
          incr_tx <= ln_tx2;
          incr_ty <= ln_ty1;
        end
      end
    end
  end

endmodule

/* hw/rtl/crg_back.sv */
// ----------------------------------------------------------------------------
// crg_back
// Expands each queued step into its mirrored points or spans, one result
// per cycle while results are popped, through a single output register.
// ----------------------------------------------------------------------------
module crg_back import crg_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int OW          = RADIUS_BITS + 2,
  parameter int EW          = 2 + 2 * COORD_BITS + 2 * OW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic [EW-1:0]              q_data,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic                       is_span,
  output logic signed [OUT_BITS-1:0] x_start,
  output logic signed [OUT_BITS-1:0] x_end,
  output logic signed [OUT_BITS-1:0] y_pos,
  output logic                       last,
  output logic                       finished
);

  localparam int SW = ((COORD_BITS > OW) ? COORD_BITS : OW) + 1;

  logic                         e_fill;
  logic                         e_fin;
  logic signed [COORD_BITS-1:0] e_cx;
  logic signed [COORD_BITS-1:0] e_cy;
  logic signed [OW-1:0]         e_maj;
  logic signed [OW-1:0]         e_min;

  logic [IDX_BITS-1:0] idx;
  logic                out_valid;
  logic                load;
  logic                at_last;

  logic signed [OW-1:0] hp;
  logic signed [OW-1:0] vp;
  logic                 hneg;
  logic                 vneg;
  logic signed [SW-1:0] xa;
  logic signed [SW-1:0] xb;
  logic signed [SW-1:0] yv;

  assign {e_fill, e_fin, e_cx, e_cy, e_maj, e_min} = q_data;

  assign empty   = !out_valid;
  assign load    = q_valid && (!out_valid || pop);
  assign at_last = (idx == ((e_fill == MODE_FILL) ? LAST_IDX_FILL : LAST_IDX_LINE));
  assign q_pop   = load && at_last;

  // Octant and span mirroring for the current result index.
  always_comb begin
    if (e_fill == MODE_FILL) begin
      if ((idx == 3'd0) || (idx == 3'd3)) begin
        hp = e_maj;
        vp = e_min;
      end else begin
        hp = e_min;
        vp = e_maj;
      end
      hneg = 1'b0;
      vneg = idx[1];
    end else begin
      hp   = idx[2] ? e_min : e_maj;
      vp   = idx[2] ? e_maj : e_min;
      hneg = idx[1];
      vneg = !idx[0];
    end
    xa = SW'(e_cx) - SW'(hp);
    xb = SW'(e_cx) + SW'(hp);
    yv = vneg ? SW'(e_cy) - SW'(vp) : SW'(e_cy) + SW'(vp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + IDX_BITS'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_span  <= e_fill;
      y_pos    <= OUT_BITS'(yv);
      last     <= at_last;
      finished <= at_last && e_fin;
      if (e_fill == MODE_FILL) begin
        x_start <= OUT_BITS'(xa);
        x_end   <= OUT_BITS'(xb);
      end else begin
        x_start <= hneg ? OUT_BITS'(xa) : OUT_BITS'(xb);
        x_end   <= hneg ? OUT_BITS'(xa) : OUT_BITS'(xb);
      end
    end
  end

endmodule

/* hw/rtl/circle_raster_generator_unit.sv */
// ----------------------------------------------------------------------------
// circle_raster_generator_unit
// Midpoint circle rasterizer giving outline points or filled spans.
// ----------------------------------------------------------------------------
// A start command gives no result. Each step command that the front takes while
// a circle is running advances the circle and queues the step; the back then
// puts out its results through the single result port, one per cycle while
// pop is held high: eight results per step in outline mode and four in fill
// mode. The result port sets the sustained rate, and up to two steps wait in
// the queue while results are drained.
module circle_raster_generator_unit import crg_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0]       circle_radius,
  input  logic                         fill_mode,
  input  logic                         pop,
  output logic                         empty,
  output logic                         is_span,
  output logic signed [OUT_BITS-1:0]   x_start,
  output logic signed [OUT_BITS-1:0]   x_end,
  output logic signed [OUT_BITS-1:0]   y_pos,
  output logic                         last,
  output logic                         finished
);

  localparam int OW = RADIUS_BITS + 2;
  localparam int EW = 2 + 2 * COORD_BITS + 2 * OW;

  logic          q_full;
  logic          q_push;
  logic [EW-1:0] q_wdata;
  logic          q_valid;
  logic [EW-1:0] q_rdata;
  logic          q_pop;

  assign full = q_full;

  crg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .OW          (OW),
    .EW          (EW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .operation     (operation),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .fill_mode     (fill_mode),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  crg_queue #(
    .W     (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rdata),
    .rd_valid (q_valid)
  );

  crg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .OW          (OW),
    .EW          (EW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .is_span  (is_span),
    .x_start  (x_start),
    .x_end    (x_end),
    .y_pos    (y_pos),
    .last     (last),
    .finished (finished)
  );

endmodule

/* bench/tb_circle_raster_generator_unit.sv */
// ----------------------------------------------------------------------------
// tb_circle_raster_generator_unit
// Self-checking bench for the circle raster generator. A directed table covers
// empty circles, the smallest circles in both modes, the coordinate extremes,
// a restart while a circle is running and steps while idle. Random circles,
// mostly small and run to their end, follow. Every result word is compared,
// field by field, with a predictor of the midpoint and filled-circle loops,
// with random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_circle_raster_generator_unit;
  import crg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB         = COORD_BITS_DEF;
  localparam int RB         = RADIUS_BITS_DEF;
  localparam int CMD_TARGET = 320;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 32;

  typedef struct packed {
    logic                       is_span;
    logic signed [OUT_BITS-1:0] x_start;
    logic signed [OUT_BITS-1:0] x_end;
    logic signed [OUT_BITS-1:0] y_pos;
    logic                       last;
    logic                       finished;
  } raster_word_t;

  // One command word; chk marks table rows whose first result is typed in.
  typedef struct {
    op_t                   op;
    logic signed [CB-1:0]  cx;
    logic signed [CB-1:0]  cy;
    logic [RB-1:0]         rad;
    mode_t                 mode;
    bit                    chk;
    raster_word_t          first;
  } circle_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic                       operation = 1'b0;
  logic signed [CB-1:0]       center_x = '0;
  logic signed [CB-1:0]       center_y = '0;
  logic [RB-1:0]              circle_radius = '0;
  logic                       fill_mode = 1'b0;
  logic                       pop = 1'b0;
  logic                       empty;
  logic                       is_span;
  logic signed [OUT_BITS-1:0] x_start;
  logic signed [OUT_BITS-1:0] x_end;
  logic signed [OUT_BITS-1:0] y_pos;
  logic                       last;
  logic                       finished;

  circle_raster_generator_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .center_x(center_x), .center_y(center_y), .circle_radius(circle_radius),
    .fill_mode(fill_mode), .pop(pop), .empty(empty), .is_span(is_span),
    .x_start(x_start), .x_end(x_end), .y_pos(y_pos), .last(last),
    .finished(finished)
  );

  // Predictor state of the running circle.
  bit    circle_live = 1'b0;
  mode_t circle_mode = MODE_LINE;
  int    org_x = 0, org_y = 0, rad_q = 0;
  int    major = 0, minor = 0, dec = 0, inc_tx = 0, inc_ty = 0;

  raster_word_t pending_words[$];
  int           fail_count = 0;
  int           cmds_fed = 0;
  int           cycles = 0;
  bit           calm = 1'b0;

  circle_cmd_t directed_seq [24] = '{
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, 12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, 12'sd0,     12'sd0,     10'd1,    MODE_LINE, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b1,
      '{1'b0, 13'sd0, 13'sd0, 13'sd0, 1'b0, 1'b0}},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, 12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b1,
      '{1'b1, 13'sd0, 13'sd0, 13'sd0, 1'b0, 1'b0}},
    '{OP_START, 12'sd2047,  -12'sd2048, 10'd1023, MODE_LINE, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b1,
      '{1'b0, 13'sd3069, 13'sd3069, -13'sd2048, 1'b0, 1'b0}},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, -12'sd2048, 12'sd2047,  10'd1023, MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b1,
      '{1'b1, -13'sd3071, -13'sd1025, 13'sd2047, 1'b0, 1'b0}},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, -12'sd1,    -12'sd1,    10'd2,    MODE_LINE, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_STEP,  -12'sd1,    -12'sd1,    10'd1023, MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_LINE, 1'b0, '0},
    '{OP_START, 12'sd5,     -12'sd7,    10'd3,    MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b0, '0},
    '{OP_STEP,  12'sd0,     12'sd0,     10'd0,    MODE_FILL, 1'b0, '0}
  };

  initial begin
    forever begin
      #1 clk = ~clk;
    end
  end

  function automatic raster_word_t make_word(bit span, int xa, int xb, int yy);
    raster_word_t w;
    w.is_span  = span;
    w.x_start  = xa[OUT_BITS-1:0];
    w.x_end    = xb[OUT_BITS-1:0];
    w.y_pos    = yy[OUT_BITS-1:0];
    w.last     = 1'b0;
    w.finished = 1'b0;
    return w;
  endfunction

  // Applies one accepted command to the circle state and returns the words
  // that it yields, oldest first.
  function automatic int rasterize(input circle_cmd_t c, output raster_word_t w[8]);
    int n;
    int px, py;
    n = 0;
    if (c.op == OP_START) begin
      org_x       = int'(c.cx);
      org_y       = int'(c.cy);
      rad_q       = int'(c.rad);
      circle_mode = c.mode;
      inc_tx      = 1;
      inc_ty      = 1;
      minor       = 0;
      if (circle_mode == MODE_FILL) begin
        major = rad_q;
        dec   = rad_q - 1;
      end else begin
        major = rad_q - 1;
        dec   = 1 - 2 * rad_q;
      end
      circle_live = (major >= minor);
      return 0;
    end
    if (!circle_live) return 0;
    px = major;
    py = minor;
    if (circle_mode == MODE_FILL) begin
      // Here major is the column offset and minor the row offset.
      w[0] = make_word(1'b1, org_x - px, org_x + px, org_y + py);
      w[1] = make_word(1'b1, org_x - py, org_x + py, org_y + px);
      w[2] = make_word(1'b1, org_x - py, org_x + py, org_y - px);
      w[3] = make_word(1'b1, org_x - px, org_x + px, org_y - py);
      if (dec >= 2 * py) begin
        dec   = dec - (2 * py + 1);
        minor = py + 1;
      end else if (dec < 2 * (rad_q - px)) begin
        dec   = dec + 2 * px - 1;
        major = px - 1;
      end else begin
        dec   = dec + 2 * (px - py - 1);
        major = px - 1;
        minor = py + 1;
      end
      n = 4;
    end else begin
      w[0] = make_word(1'b0, org_x + px, org_x + px, org_y - py);
      w[1] = make_word(1'b0, org_x + px, org_x + px, org_y + py);
      w[2] = make_word(1'b0, org_x - px, org_x - px, org_y - py);
      w[3] = make_word(1'b0, org_x - px, org_x - px, org_y + py);
      w[4] = make_word(1'b0, org_x + py, org_x + py, org_y - px);
      w[5] = make_word(1'b0, org_x + py, org_x + py, org_y + px);
      w[6] = make_word(1'b0, org_x - py, org_x - py, org_y - px);
      w[7] = make_word(1'b0, org_x - py, org_x - py, org_y + px);
      // Both branches may fire in one iteration, the second seeing the
      // updated error term.
      if (dec <= 0) begin
        minor  = minor + 1;
        dec    = dec + inc_ty;
        inc_ty = inc_ty + 2;
      end
      if (dec > 0) begin
        major  = major - 1;
        inc_tx = inc_tx + 2;
        dec    = dec + inc_tx - 2 * rad_q;
      end
      n = 8;
    end
    circle_live       = (major >= minor);
    w[n-1].last     = 1'b1;
    w[n-1].finished = !circle_live;
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic circle_cmd_t random_cmd(op_t op, int rad);
    circle_cmd_t c;
    c.op    = op;
    c.cx    = CB'($urandom);
    c.cy    = CB'($urandom);
    c.rad   = rad[RB-1:0];
    c.mode  = mode_t'($urandom_range(0, 1));
    c.chk   = 1'b0;
    c.first = '0;
    return c;
  endfunction

  task automatic send_cmd(input circle_cmd_t c);
    raster_word_t w[8];
    int n;
    int gap;
    push          <= 1'b1;
    operation     <= c.op;
    center_x      <= c.cx;
    center_y      <= c.cy;
    circle_radius <= c.rad;
    fill_mode     <= c.mode;
    do @(posedge clk); while (full);
    if (c.op == OP_START || circle_live) cmds_fed++;
    n = rasterize(c, w);
    if (c.chk && n > 0) w[0] = c.first;
    for (int i = 0; i < n; i++) pending_words.push_back(w[i]);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void check_field(string nm, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, nm, want, got);
      fail_count++;
    end
  endfunction

  // Result side: compare each accepted word, then choose the next pop.
  initial begin
    raster_word_t want;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, x_start %0d y_pos %0d", $time, x_start, y_pos);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          check_field("is_span", want.is_span, is_span);
          check_field("x_start", want.x_start, x_start);
          check_field("x_end", want.x_end, x_end);
          check_field("y_pos", want.y_pos, y_pos);
          check_field("last", want.last, last);
          check_field("finished", want.finished, finished);
        end
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop   <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Alternates stretches with and without idling on both sides.
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("circle_raster_generator_unit: mismatch");
    $finish;
  end

  initial begin
    circle_cmd_t c;
    int rad;
    int kind;
    int cap;
    int steps;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_seq[i]) send_cmd(directed_seq[i]);

    while (cmds_fed < CMD_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_cmd(random_cmd(OP_STEP, $urandom));
      end else begin
        // Mostly small circles run to their end; large ones are cut short.
        kind = $urandom_range(0, 99);
        if (kind < 8) rad = $urandom_range(64, 1023);
        else if (kind < 28) rad = $urandom_range(16, 63);
        else rad = $urandom_range(0, 15);
        cap = (rad > 63) ? $urandom_range(1, 12) : 2000;
        send_cmd(random_cmd(OP_START, rad));
        steps = 0;
        while (circle_live && steps < cap && $urandom_range(0, 99) >= 3) begin
          send_cmd(random_cmd(OP_STEP, $urandom));
          steps++;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) send_cmd(random_cmd(OP_STEP, $urandom));
        end
      end
    end
    push <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("circle_raster_generator_unit: match");
    end else begin
      $display("circle_raster_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
